[sv/slhf_pkg.sv]
// ----------------------------------------------------------------------------
// slhf_pkg
// Types and constants shared by the SPI length header framer.
// ----------------------------------------------------------------------------
`default_nettype none

package slhf_pkg;

  typedef enum logic [1:0] {
    OP_START_WRITE = 2'd0,
    OP_PAYLOAD     = 2'd1,
    OP_START_READ  = 2'd2,
    OP_RX_BYTE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_BODY = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  localparam logic [7:0]  CMD_WRITE   = 8'h01;
  localparam logic [7:0]  CMD_READ    = 8'h03;
  localparam logic [16:0] HDR_LEN     = 17'd5;
  localparam logic [16:0] LEN_HI_POS  = 17'd4;
  localparam int unsigned MAX_RESULTS = 6;
  localparam int unsigned CNT_W       = 3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] res;
    logic [CNT_W-1:0]       cnt;
  } burst_t;

endpackage

`default_nettype wire

[sv/slhf_frame_ctrl.sv]
// ----------------------------------------------------------------------------
// slhf_frame_ctrl
// Frame state and per-transfer result list for write and read frames.
// ----------------------------------------------------------------------------
`default_nettype none

module slhf_frame_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire slhf_pkg::in_item_t item_i,
  output slhf_pkg::burst_t       burst_o
);

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_RHDR  = 2'd2,
    MODE_RBODY = 2'd3
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [15:0] payload_left_q, payload_left_d;
  logic        pad_needed_q, pad_needed_d;
  logic [16:0] rx_count_q, rx_count_d;
  logic [16:0] rx_expected_q, rx_expected_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] fillers_left_q, fillers_left_d;

  logic        pad;
  logic [15:0] padded;
  logic [16:0] rx_inc;
  logic [16:0] sent_wr;
  logic [16:0] sent_rd;
  logic [15:0] body_size;

  assign pad       = ~item_i.payload_length[0];
  assign padded    = item_i.payload_length + {15'd0, pad};
  assign rx_inc    = rx_count_q + 17'd1;
  assign sent_wr   = rx_expected_q - {1'b0, payload_left_q} - {16'd0, pad_needed_q};
  assign sent_rd   = rx_expected_q - {1'b0, fillers_left_q};
  assign body_size = {length_high_q, item_i.data_byte};

  always_comb begin
    mode_d         = mode_q;
    payload_left_d = payload_left_q;
    pad_needed_d   = pad_needed_q;
    rx_count_d     = rx_count_q;
    rx_expected_d  = rx_expected_q;
    length_high_d  = length_high_q;
    fillers_left_d = fillers_left_q;
    burst_o        = '0;
    if (accept_i) begin
      case (item_i.opcode)
        slhf_pkg::OP_START_WRITE: begin
          if (mode_q == MODE_IDLE) begin
            payload_left_d  = item_i.payload_length;
            rx_count_d      = '0;
            rx_expected_d   = {1'b0, item_i.payload_length} + {16'd0, pad}
                              + slhf_pkg::HDR_LEN;
            mode_d          = MODE_WRITE;
            burst_o.res[0]  = '{kind: slhf_pkg::KIND_TX, data: slhf_pkg::CMD_WRITE};
            burst_o.res[1]  = '{kind: slhf_pkg::KIND_TX, data: padded[15:8]};
            burst_o.res[2]  = '{kind: slhf_pkg::KIND_TX, data: padded[7:0]};
            if (item_i.payload_length == 16'd0) begin
              pad_needed_d = 1'b0;
              burst_o.cnt  = 3'd6;
            end else begin
              pad_needed_d = pad;
              burst_o.cnt  = 3'd5;
            end
          end
        end
        slhf_pkg::OP_PAYLOAD: begin
          if (mode_q == MODE_WRITE && payload_left_q != 16'd0) begin
            payload_left_d = payload_left_q - 16'd1;
            burst_o.res[0] = '{kind: slhf_pkg::KIND_TX, data: item_i.data_byte};
            burst_o.cnt    = 3'd1;
            if (payload_left_d == 16'd0 && pad_needed_q) begin
              pad_needed_d = 1'b0;
              burst_o.cnt  = 3'd2;
            end
          end
        end
        slhf_pkg::OP_START_READ: begin
          if (mode_q == MODE_IDLE) begin
            rx_count_d     = '0;
            rx_expected_d  = slhf_pkg::HDR_LEN;
            length_high_d  = '0;
            fillers_left_d = '0;
            mode_d         = MODE_RHDR;
            burst_o.res[0] = '{kind: slhf_pkg::KIND_TX, data: slhf_pkg::CMD_READ};
            burst_o.cnt    = 3'd5;
          end
        end
        slhf_pkg::OP_RX_BYTE: begin
          case (mode_q)
            MODE_WRITE: begin
              if (rx_count_q < sent_wr) begin
                rx_count_d = rx_inc;
                if (rx_inc == rx_expected_q) begin
                  mode_d         = MODE_IDLE;
                  burst_o.res[0] = '{kind: slhf_pkg::KIND_END, data: 8'd0};
                  burst_o.cnt    = 3'd1;
                end
              end
            end
            MODE_RHDR: begin
              rx_count_d = rx_inc;
              if (rx_inc == slhf_pkg::LEN_HI_POS) begin
                length_high_d = item_i.data_byte;
              end else if (rx_inc == slhf_pkg::HDR_LEN) begin
                burst_o.cnt = 3'd1;
                if (body_size == 16'd0) begin
                  mode_d         = MODE_IDLE;
                  burst_o.res[0] = '{kind: slhf_pkg::KIND_END, data: 8'd0};
                end else begin
                  rx_expected_d  = {1'b0, body_size} + slhf_pkg::HDR_LEN;
                  fillers_left_d = body_size - 16'd1;
                  mode_d         = MODE_RBODY;
                end
              end
            end
            MODE_RBODY: begin
              if (rx_count_q < sent_rd) begin
                rx_count_d     = rx_inc;
                burst_o.res[0] = '{kind: slhf_pkg::KIND_BODY, data: item_i.data_byte};
                burst_o.cnt    = 3'd1;
                if (rx_inc == rx_expected_q) begin
                  mode_d         = MODE_IDLE;
                  burst_o.res[1] = '{kind: slhf_pkg::KIND_END, data: 8'd0};
                  burst_o.cnt    = 3'd2;
                end else if (fillers_left_q != 16'd0) begin
                  fillers_left_d = fillers_left_q - 16'd1;
                  burst_o.cnt    = 3'd2;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_IDLE;
      payload_left_q <= '0;
      pad_needed_q   <= 1'b0;
      rx_count_q     <= '0;
      rx_expected_q  <= '0;
      length_high_q  <= '0;
      fillers_left_q <= '0;
    end else begin
      mode_q         <= mode_d;
      payload_left_q <= payload_left_d;
      pad_needed_q   <= pad_needed_d;
      rx_count_q     <= rx_count_d;
      rx_expected_q  <= rx_expected_d;
      length_high_q  <= length_high_d;
      fillers_left_q <= fillers_left_d;
    end
  end

endmodule

`default_nettype wire

[sv/spi_length_header_framer.sv]
// ----------------------------------------------------------------------------
// spi_length_header_framer
// Host-side SPI framing with a length header for write and read frames.
// ----------------------------------------------------------------------------
//   channel  | signals                            | carries
//   ---------+------------------------------------+--------------------------
//   in       | in_valid_i, in_ready_o, in_item_i  | opcode, length, byte
//   out      | out_valid_o, out_ready_i, out_item_o | kind, out_byte, last
//
// An input transfer loads its results (0 to 6) into a result queue that
// drives one result per cycle while out_ready_i is high. A transfer's
// results occupy the queue until the last one leaves; the next input is
// taken in the cycle the last result of the previous one leaves.
// Reset clears the frame state and empties the queue.
// A stalled output holds the head result and blocks further input.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_length_header_framer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire slhf_pkg::in_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output slhf_pkg::out_item_t     out_item_o
);

  localparam int unsigned N = slhf_pkg::MAX_RESULTS;

  slhf_pkg::burst_t           burst;
  slhf_pkg::res_t [N-1:0]     res_q, res_d;
  logic [slhf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       in_fire;
  logic                       out_fire;

  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign in_ready_o  = (cnt_q == '0) | ((cnt_q == 3'd1) & out_ready_i);
  assign in_fire     = in_valid_i & in_ready_o;

  assign out_item_o.kind     = res_q[0].kind;
  assign out_item_o.out_byte = res_q[0].data;
  assign out_item_o.last     = (cnt_q == 3'd1);

  slhf_frame_ctrl u_frame_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_fire),
    .item_i   (in_item_i),
    .burst_o  (burst)
  );

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (out_fire) begin
      for (int i = 0; i < N - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      res_d[N-1] = '0;
      cnt_d      = cnt_q - 3'd1;
    end
    if (in_fire && burst.cnt != '0) begin
      res_d = burst.res;
      cnt_d = burst.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

[sv/slhf_checker.sv]
// ----------------------------------------------------------------------------
// slhf_checker
// Port-level checks on the SPI length header framer.
// ----------------------------------------------------------------------------
`default_nettype none

module slhf_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire slhf_pkg::out_item_t out_item_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("output transfer changed while stalled");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_item_i.last |=> out_valid_i)
    else $error("result run broken before its last result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending result");

  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.kind == slhf_pkg::KIND_END
    |-> out_item_i.last && out_item_i.out_byte == 8'd0)
    else $error("frame end not last or not zero");

endmodule

bind spi_length_header_framer slhf_checker u_slhf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire

[tb/slhf_tb_pkg.sv]
// ----------------------------------------------------------------------------
// slhf_tb_pkg
// Scoreboard for the SPI length header framer: tracks the frame state of
// the block for every input transfer and checks output transfers in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package slhf_tb_pkg;

  import slhf_pkg::*;

  typedef enum logic [1:0] {
    FRAME_IDLE      = 2'd0,
    FRAME_WRITE     = 2'd1,
    FRAME_READ_HDR  = 2'd2,
    FRAME_READ_BODY = 2'd3
  } frame_state_e;

  class frame_scoreboard;

    out_item_t    framing_due[$];
    int unsigned  errors;
    frame_state_e state;
    logic [15:0]  payload_left;
    logic         pad_needed;
    logic [16:0]  rx_count;
    logic [16:0]  rx_expected;
    logic [7:0]   length_high;
    logic [15:0]  fillers_left;

    function new();
      errors       = 0;
      state        = FRAME_IDLE;
      payload_left = '0;
      pad_needed   = 1'b0;
      rx_count     = '0;
      rx_expected  = '0;
      length_high  = '0;
      fillers_left = '0;
    endfunction

    function void emit(kind_e kind, logic [7:0] value);
      out_item_t r;
      r.kind     = kind;
      r.out_byte = value;
      r.last     = 1'b0;
      framing_due.push_back(r);
    endfunction

    function void frame_input(in_item_t it);
      int          first;
      logic [16:0] padded_wide;
      logic [15:0] padded;
      logic [16:0] sent;
      logic [15:0] body_size;
      first = framing_due.size();
      case (op_e'(it.opcode))
        OP_START_WRITE: begin
          if (state == FRAME_IDLE) begin
            pad_needed   = ~it.payload_length[0];
            padded_wide  = {1'b0, it.payload_length} + pad_needed;
            padded       = (padded_wide > 17'h0ffff) ? 16'hffff : padded_wide[15:0];
            payload_left = it.payload_length;
            rx_count     = '0;
            rx_expected  = padded_wide + HDR_LEN;
            state        = FRAME_WRITE;
            emit(KIND_TX, CMD_WRITE);
            emit(KIND_TX, padded[15:8]);
            emit(KIND_TX, padded[7:0]);
            emit(KIND_TX, 8'h00);
            emit(KIND_TX, 8'h00);
            if (payload_left == 0 && pad_needed) begin
              pad_needed = 1'b0;
              emit(KIND_TX, 8'h00);
            end
          end
        end
        OP_PAYLOAD: begin
          if (state == FRAME_WRITE && payload_left != 0) begin
            payload_left = payload_left - 1'b1;
            emit(KIND_TX, it.data_byte);
            if (payload_left == 0 && pad_needed) begin
              pad_needed = 1'b0;
              emit(KIND_TX, 8'h00);
            end
          end
        end
        OP_START_READ: begin
          if (state == FRAME_IDLE) begin
            rx_count     = '0;
            rx_expected  = HDR_LEN;
            length_high  = '0;
            fillers_left = '0;
            state        = FRAME_READ_HDR;
            emit(KIND_TX, CMD_READ);
            repeat (4) emit(KIND_TX, 8'h00);
          end
        end
        OP_RX_BYTE: begin
          case (state)
            FRAME_WRITE: begin
              sent = rx_expected - payload_left - pad_needed;
              if (rx_count < sent) begin
                rx_count = rx_count + 1'b1;
                if (rx_count == rx_expected) begin
                  state = FRAME_IDLE;
                  emit(KIND_END, 8'h00);
                end
              end
            end
            FRAME_READ_HDR: begin
              rx_count = rx_count + 1'b1;
              if (rx_count == LEN_HI_POS) begin
                length_high = it.data_byte;
              end else if (rx_count == HDR_LEN) begin
                body_size = {length_high, it.data_byte};
                if (body_size == 0) begin
                  state = FRAME_IDLE;
                  emit(KIND_END, 8'h00);
                end else begin
                  rx_expected  = {1'b0, body_size} + HDR_LEN;
                  fillers_left = body_size - 1'b1;
                  state        = FRAME_READ_BODY;
                  emit(KIND_TX, 8'h00);
                end
              end
            end
            FRAME_READ_BODY: begin
              sent = rx_expected - fillers_left;
              if (rx_count < sent) begin
                rx_count = rx_count + 1'b1;
                emit(KIND_BODY, it.data_byte);
                if (rx_count == rx_expected) begin
                  state = FRAME_IDLE;
                  emit(KIND_END, 8'h00);
                end else if (fillers_left != 0) begin
                  fillers_left = fillers_left - 1'b1;
                  emit(KIND_TX, 8'h00);
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
      if (framing_due.size() > first) begin
        framing_due[framing_due.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (framing_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                 $time, got.kind, got.out_byte, got.last);
        return;
      end
      want = framing_due.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want.kind, got.kind);
      end
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                 $time, want.out_byte, got.out_byte);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, got.last);
      end
    endfunction

  endclass

endpackage

[tb/tb_spi_length_header_framer.sv]
// ----------------------------------------------------------------------------
// tb_spi_length_header_framer
// Drives write and read frames, strays and busy starts into the framer under
// random valid/ready gaps and a long output stall, and checks every output
// transfer against the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spi_length_header_framer;

  import slhf_pkg::*;
  import slhf_tb_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 54;
  int unsigned frame_items   = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;

  frame_scoreboard board = new();

  spi_length_header_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.frame_input(in_item);
      end
      if (out_valid && out_ready) begin
        board.check_result(out_item);
      end
    end
  end

  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] any_len();
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic in_item_t pack_item(op_e op, logic [15:0] len, logic [7:0] value);
    in_item_t it;
    it.opcode         = op;
    it.payload_length = len;
    it.data_byte      = value;
    return it;
  endfunction

  task automatic offer(input in_item_t it, input bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (counted) frame_items++;
  endtask

  task automatic send_rx(input logic [7:0] value);
    offer(pack_item(OP_RX_BYTE, any_len(), value), 1'b1);
  endtask

  task automatic write_frame(input logic [15:0] len, input bit noisy);
    int unsigned given;
    int unsigned echoed;
    int unsigned total;
    int unsigned sent;
    logic        pad;
    pad    = ~len[0];
    given  = 0;
    echoed = 0;
    total  = len + pad + 5;
    offer(pack_item(OP_START_WRITE, len, any_byte()), 1'b1);
    while (echoed < total) begin
      sent = 5 + given + ((given == len) ? pad : 0);
      if (noisy && $urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: offer(pack_item(OP_START_WRITE, any_len(), any_byte()), 1'b0);
          1: offer(pack_item(OP_START_READ, any_len(), any_byte()), 1'b0);
          2: offer(pack_item(given == len ? OP_PAYLOAD : OP_START_READ,
                             any_len(), any_byte()), 1'b0);
          default: offer(pack_item(echoed == sent ? OP_RX_BYTE : OP_START_WRITE,
                                   any_len(), any_byte()), 1'b0);
        endcase
      end else if (given < len && (echoed == sent || $urandom_range(1) == 1)) begin
        offer(pack_item(OP_PAYLOAD, any_len(), any_byte()), 1'b1);
        given++;
      end else begin
        send_rx(any_byte());
        echoed++;
      end
    end
  endtask

  task automatic read_frame(input logic [15:0] size, input bit noisy);
    offer(pack_item(OP_START_READ, any_len(), any_byte()), 1'b1);
    for (int i = 1; i <= 5 + size; i++) begin
      if (noisy && $urandom_range(7) == 0) begin
        offer(pack_item($urandom_range(1) ? OP_PAYLOAD : OP_START_WRITE,
                        any_len(), any_byte()), 1'b0);
      end
      send_rx(i == 4 ? size[15:8] : (i == 5 ? size[7:0] : any_byte()));
    end
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'($urandom_range(13, 24));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin : stimulus
    bit held;
    int drain;
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // strays in idle
    offer(pack_item(OP_RX_BYTE, 16'h0000, 8'hff), 1'b0);
    offer(pack_item(OP_PAYLOAD, 16'hffff, 8'h00), 1'b0);

    // empty write payload, busy start-read
    offer(pack_item(OP_START_WRITE, 16'd0, 8'h00), 1'b1);
    offer(pack_item(OP_START_READ, 16'h0000, 8'h00), 1'b0);
    repeat (6) send_rx(8'h00);

    // one-byte write with stray echo and stray payload
    offer(pack_item(OP_START_WRITE, 16'd1, 8'hff), 1'b1);
    repeat (5) send_rx(8'hff);
    offer(pack_item(OP_RX_BYTE, 16'h0000, 8'h5a), 1'b0);
    offer(pack_item(OP_PAYLOAD, 16'h0000, 8'hff), 1'b1);
    offer(pack_item(OP_PAYLOAD, 16'hffff, 8'h00), 1'b0);
    send_rx(8'h00);

    // empty read body, busy start-write with top length
    offer(pack_item(OP_START_READ, 16'h0000, 8'h00), 1'b1);
    offer(pack_item(OP_START_WRITE, 16'hffff, 8'hff), 1'b0);
    send_rx(8'hff);
    send_rx(8'h00);
    send_rx(8'hff);
    send_rx(8'h00);
    send_rx(8'h00);

    while (frame_items < 230) begin
      if (frame_items >= 150) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (frame_items >= 75) begin
        send_idle_pct = 54;
        recv_idle_pct = 8;
      end
      if (!held && frame_items >= 40) begin
        held = 1'b1;
        holds_asked++;
        write_frame(16'd40, 1'b0);
      end else begin
        case ($urandom_range(9))
          0:             repeat ($urandom_range(1, 4))
                           offer(pack_item($urandom_range(1) ? OP_PAYLOAD : OP_RX_BYTE,
                                           any_len(), any_byte()), 1'b0);
          1, 2, 3, 4, 5: write_frame(pick_size(), 1'b1);
          default:       read_frame(pick_size(), 1'b1);
        endcase
      end
    end

    // top write length, frame left open
    offer(pack_item(OP_START_WRITE, 16'hffff, 8'h00), 1'b1);
    offer(pack_item(OP_PAYLOAD, any_len(), any_byte()), 1'b1);
    send_rx(any_byte());
    send_rx(any_byte());
    in_valid <= 1'b0;

    for (drain = 0; drain < 20000 && board.framing_due.size() != 0; drain++) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (board.framing_due.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived", $time, board.framing_due.size());
    end
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
